// File: rtl/pan_pkg.sv
// Package for the peak audio normalizer: widths, register indexes and beat types.
// Depends on nothing; every rtl file imports it.
`timescale 1ns / 1ps
`default_nettype none

package pan_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 10;
    localparam int TARGET_W = 15;
    localparam int AMP_W    = 6;

    localparam int PEAK_W = SAMPLE_W;
    localparam int GAIN_W = AMP_W + FRAC_W;
    localparam int DVD_W  = ((TARGET_W > SAMPLE_W - 1) ? TARGET_W : SAMPLE_W - 1) + FRAC_W;
    localparam int PROD_W = SAMPLE_W + 1 + GAIN_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TARGET_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_PEAK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AMP    = 2'd2;

    localparam logic [TARGET_W-1:0] TARGET_RST  = TARGET_W'(24575);
    localparam logic [AMP_W-1:0]    MAX_AMP_RST = AMP_W'(32);
    localparam logic [GAIN_W-1:0]   UNITY       = GAIN_W'(1 << FRAC_W);
    localparam logic [SAMPLE_W-2:0] FULL_SCALE  = '1;

    typedef struct packed {
        logic                       command;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       block_end;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last_out;
    } t_out_beat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// File: rtl/pan_div.sv
// Restoring divider for the gain: one quotient bit per cycle.
// Depends on pan_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pan_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pan_pkg::DVD_W-1:0]   i_dividend,
    input  wire logic [pan_pkg::PEAK_W-1:0]  i_divisor,
    output pan_pkg::t_div_stat               o_stat,
    output logic      [pan_pkg::DVD_W-1:0]   o_quotient
);
    import pan_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PEAK_W-1:0] r_rem;
    logic [PEAK_W-1:0] r_dvs;
    logic [DVD_W-1:0]  r_quo;

    logic [PEAK_W:0]   w_trial;
    logic [PEAK_W:0]   w_diff;
    logic              w_fits;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_fits  = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift the dividend out while the quotient shifts in behind it
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[PEAK_W-1:0] : w_trial[PEAK_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

`default_nettype wire

// File: rtl/pan_mul.sv
// Registered signed multiplier shared by the overflow check and the gain apply.
// Depends on pan_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pan_mul (
    input  wire logic                             i_clk,
    input  wire logic signed [pan_pkg::SAMPLE_W:0] i_a,
    input  wire logic        [pan_pkg::GAIN_W-1:0] i_b,
    output logic signed      [pan_pkg::PROD_W-1:0] o_prod
);
    import pan_pkg::*;

    logic signed [GAIN_W:0]   w_b;
    logic signed [PROD_W-1:0] r_prod;

    assign w_b = $signed({1'b0, i_b});

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a * w_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: rtl/peak_audio_normalizer.sv
// Top level of the peak audio normalizer: config registers, sequencer, output register.
// Depends on pan_pkg, pan_div and pan_mul.
//
//  channel   direction  handshake             payload
//  in        in         i_in_valid/o_in_stall    i_in_data   (t_in_beat)
//  out       out        o_out_valid/i_out_stall  o_out_data  (t_out_beat)
//  cfg       in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// A measure beat is taken in S_IDLE. An apply beat with a cached gain passes S_APPLY_MUL
// and S_APPLY_OUT. The first apply beat after a measure beat or a config write recomputes
// the gain on the bit-serial divider, and a second division follows when the full-scale
// limit is exceeded. The divider runs 25 steps, one quotient bit each.
// Reset is synchronous, active low: peak 1, gain unity and not cached.
// The input stalls while a beat is in work; a stalled output holds the apply beat.
`timescale 1ns / 1ps
`default_nettype none

module peak_audio_normalizer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire pan_pkg::t_in_beat               i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output pan_pkg::t_out_beat                   o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pan_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pan_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pan_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DIV       = 7'b0000010,
        S_CHK_MUL   = 7'b0000100,
        S_CHK_EVAL  = 7'b0001000,
        S_DIV2      = 7'b0010000,
        S_APPLY_MUL = 7'b0100000,
        S_APPLY_OUT = 7'b1000000
    } t_state;

    localparam logic signed [PROD_W-1:0] Q_MAX = PROD_W'(FULL_SCALE);
    localparam logic signed [PROD_W-1:0] Q_MIN = ~Q_MAX;

    t_state                     r_state, n_state;
    logic                       r_reset_peak, n_reset_peak;
    logic [TARGET_W-1:0]        r_target, n_target;
    logic [AMP_W-1:0]           r_max_amp, n_max_amp;
    logic [PEAK_W-1:0]          r_peak, n_peak;
    logic [GAIN_W-1:0]          r_gain, n_gain;
    logic                       r_gain_valid, n_gain_valid;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic                       r_last, n_last;
    logic                       r_out_valid, n_out_valid;
    t_out_beat                  r_out_data, n_out_data;

    logic                       w_in_acc;
    logic [PEAK_W-1:0]          w_mag;
    logic                       w_div_start;
    logic [DVD_W-1:0]           w_dividend;
    logic [PEAK_W-1:0]          w_divisor;
    t_div_stat                  w_div_stat;
    logic [DVD_W-1:0]           w_quo;
    logic [GAIN_W-1:0]          w_ceil;
    logic [GAIN_W-1:0]          w_gain_hi;
    logic [GAIN_W-1:0]          w_gain_clamp;
    logic signed [SAMPLE_W:0]   w_mul_a;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_prod_q;
    logic signed [PROD_W-1:0]   w_sat;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_mag     = i_in_data.sample_in[SAMPLE_W-1] ? PEAK_W'(-i_in_data.sample_in)
                                                      : PEAK_W'(i_in_data.sample_in);
    assign w_divisor = (r_peak == '0) ? PEAK_W'(1) : r_peak;

    assign w_ceil       = {r_max_amp, {FRAC_W{1'b0}}};
    assign w_gain_hi    = (w_quo > DVD_W'(w_ceil)) ? w_ceil : w_quo[GAIN_W-1:0];
    assign w_gain_clamp = (w_gain_hi < UNITY) ? UNITY : w_gain_hi;

    assign w_mul_a  = (r_state == S_CHK_MUL) ? $signed({1'b0, r_peak})
                                             : $signed({r_sample[SAMPLE_W-1], r_sample});
    assign w_prod_q = w_prod >>> FRAC_W;
    assign w_sat    = (w_prod_q > Q_MAX) ? Q_MAX : ((w_prod_q < Q_MIN) ? Q_MIN : w_prod_q);

    pan_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    pan_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (r_gain),
        .o_prod (w_prod)
    );

    always_comb begin
        n_state      = r_state;
        n_reset_peak = r_reset_peak;
        n_target     = r_target;
        n_max_amp    = r_max_amp;
        n_peak       = r_peak;
        n_gain       = r_gain;
        n_gain_valid = r_gain_valid;
        n_sample     = r_sample;
        n_last       = r_last;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        w_div_start  = 1'b0;
        w_dividend   = DVD_W'(r_target) << FRAC_W;

        // drop the output beat once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (!i_in_data.command) begin
                        if (w_mag > r_peak) begin
                            n_peak = w_mag;
                        end
                        n_gain_valid = 1'b0;
                    end else begin
                        n_sample = i_in_data.sample_in;
                        n_last   = i_in_data.block_end;
                        if (r_gain_valid) begin
                            n_state = S_APPLY_MUL;
                        end else begin
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_gain  = w_gain_clamp;
                    n_state = S_CHK_MUL;
                end
            end
            S_CHK_MUL: begin
                n_state = S_CHK_EVAL;
            end
            S_CHK_EVAL: begin
                // peak times gain past full scale: redo as full scale over peak
                if (w_prod_q > Q_MAX) begin
                    w_div_start = 1'b1;
                    w_dividend  = DVD_W'(FULL_SCALE) << FRAC_W;
                    n_state     = S_DIV2;
                end else begin
                    n_gain_valid = 1'b1;
                    n_state      = S_APPLY_MUL;
                end
            end
            S_DIV2: begin
                if (w_div_stat.done) begin
                    n_gain       = w_quo[GAIN_W-1:0];
                    n_gain_valid = 1'b1;
                    n_state      = S_APPLY_MUL;
                end
            end
            S_APPLY_MUL: begin
                n_state = S_APPLY_OUT;
            end
            S_APPLY_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out_data.sample_out = w_sat[SAMPLE_W-1:0];
                    n_out_data.last_out   = r_last;
                    if (r_last && r_reset_peak) begin
                        n_peak       = PEAK_W'(1);
                        n_gain_valid = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RESET_PEAK: begin
                    n_reset_peak = i_cfg_data[0];
                    n_gain_valid = 1'b0;
                end
                CFG_TARGET: begin
                    n_target     = i_cfg_data[TARGET_W-1:0];
                    n_gain_valid = 1'b0;
                end
                CFG_MAX_AMP: begin
                    n_max_amp    = i_cfg_data[AMP_W-1:0];
                    n_gain_valid = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_reset_peak <= 1'b1;
            r_target     <= TARGET_RST;
            r_max_amp    <= MAX_AMP_RST;
            r_peak       <= PEAK_W'(1);
            r_gain       <= UNITY;
            r_gain_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_reset_peak <= n_reset_peak;
            r_target     <= n_target;
            r_max_amp    <= n_max_amp;
            r_peak       <= n_peak;
            r_gain       <= n_gain;
            r_gain_valid <= n_gain_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_last     <= n_last;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: test/tb_peak_audio_normalizer.sv
// Testbench for peak_audio_normalizer: directed and random beats checked against
// a cycle-free model of peak tracking, gain division and saturated scaling.
// Depends on pan_pkg and the peak_audio_normalizer RTL.
`timescale 1ns / 1ps

module tb_peak_audio_normalizer;

    import pan_pkg::*;

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_APPLY   = 1'b1;

    localparam int     IDLE_PAUSE   = 100;   // covers the longest gain recompute, with a second division
    localparam int     QUIET_LIMIT  = 2000;
    localparam int     PHASES       = 8;
    localparam int     PHASE_BEATS  = 125;
    localparam longint SAMPLE_MAX   = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN   = -SAMPLE_MAX - 1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_beat              i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_beat             o_out_data;
    logic                  o_cfg_ready;

    peak_audio_normalizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state and register copies
    logic                mode_single_pass = 1'b1;
    logic [TARGET_W-1:0] level_target     = TARGET_RST;
    logic [AMP_W-1:0]    amp_limit        = MAX_AMP_RST;
    logic [PEAK_W-1:0]   loudest_mag      = PEAK_W'(1);
    logic [GAIN_W-1:0]   gain_word        = UNITY;
    logic                gain_fresh       = 1'b0;

    t_out_beat scaled_samples [$];
    t_out_beat want;
    int        mismatches   = 0;
    int        quiet_cycles = 0;
    int        out_hold_cnt = 0;
    bit        idle_on      = 1'b1;

    function automatic logic [GAIN_W-1:0] normalize_gain();
        longint unsigned pk, quo, cap, tgt, full;
        full = FULL_SCALE;
        tgt  = level_target;
        pk   = (loudest_mag == 0) ? 1 : loudest_mag;
        quo  = (tgt << FRAC_W) / pk;
        cap  = longint'(amp_limit) << FRAC_W;
        if (quo > cap) quo = cap;
        if (quo < UNITY) quo = UNITY;
        // pull the gain back when the peak would clip
        if (((pk * quo) >> FRAC_W) > full) quo = (full << FRAC_W) / pk;
        return quo[GAIN_W-1:0];
    endfunction

    task automatic track_beat(input t_in_beat b);
        longint    smp, mag, gl, scaled;
        t_out_beat r;
        smp = $signed(b.sample_in);
        if (b.command == CMD_MEASURE) begin
            mag = (smp < 0) ? -smp : smp;
            if (mag > loudest_mag) loudest_mag = mag[PEAK_W-1:0];
            gain_fresh = 1'b0;
        end else begin
            if (!gain_fresh) begin
                gain_word  = normalize_gain();
                gain_fresh = 1'b1;
            end
            gl     = gain_word;
            scaled = (smp * gl) >>> FRAC_W;
            if (scaled > SAMPLE_MAX) scaled = SAMPLE_MAX;
            if (scaled < SAMPLE_MIN) scaled = SAMPLE_MIN;
            r.sample_out = scaled[SAMPLE_W-1:0];
            r.last_out   = b.block_end;
            scaled_samples.insert(scaled_samples.size(), r);
            if (b.block_end && mode_single_pass) begin
                loudest_mag = PEAK_W'(1);
                gain_fresh  = 1'b0;
            end
        end
    endtask

    task automatic send_item(input logic cmd, input logic signed [SAMPLE_W-1:0] smp,
                             input logic last);
        t_in_beat b;
        b.command   = cmd;
        b.sample_in = smp;
        b.block_end = last;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        track_beat(b);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RESET_PEAK: mode_single_pass = val[0];
            CFG_TARGET:     level_target     = val[TARGET_W-1:0];
            CFG_MAX_AMP:    amp_limit        = val[AMP_W-1:0];
            default:        ;
        endcase
        gain_fresh = 1'b0;
    endtask

    task automatic apply_config(input logic rp, input logic [TARGET_W-1:0] tgt,
                                input logic [AMP_W-1:0] amp);
        write_reg(CFG_RESET_PEAK, CFG_DATA_W'(rp));
        write_reg(CFG_TARGET, CFG_DATA_W'(tgt));
        write_reg(CFG_MAX_AMP, CFG_DATA_W'(amp));
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, let every result drain, then cover a trailing gain computation.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (scaled_samples.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic test_unity_and_clipping();
        // peak starts at 1, so the gain sits at the amplification ceiling
        send_item(CMD_APPLY, 16'sd0, 1'b0);
        send_item(CMD_APPLY, 16'sd1, 1'b0);
        send_item(CMD_APPLY, -16'sd1, 1'b0);
        send_item(CMD_APPLY, 16'sh7FFF, 1'b0);
        send_item(CMD_APPLY, 16'sh8000, 1'b1);
    endtask

    task automatic test_peak_tracking();
        send_item(CMD_MEASURE, 16'sd1000, 1'b0);
        send_item(CMD_MEASURE, -16'sd3000, 1'b1);   // block end on a measure is ignored
        send_item(CMD_MEASURE, 16'sd200, 1'b0);
        send_item(CMD_APPLY, 16'sd3000, 1'b0);
        send_item(CMD_APPLY, -16'sd3000, 1'b0);
        send_item(CMD_APPLY, -16'sd7, 1'b0);        // floor, not truncation
        send_item(CMD_APPLY, 16'sd12345, 1'b1);
    endtask

    task automatic test_full_scale_negative();
        // magnitude one past full scale forces the gain just below unity
        send_item(CMD_MEASURE, 16'sh8000, 1'b0);
        send_item(CMD_APPLY, 16'sh8000, 1'b0);
        send_item(CMD_APPLY, 16'sh7FFF, 1'b0);
        send_item(CMD_APPLY, -16'sd1, 1'b0);
        send_item(CMD_APPLY, 16'sd1, 1'b1);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        // zero target and zero ceiling both fall back to unity; two-pass keeps the peak
        apply_config(1'b0, '0, '0);
        send_item(CMD_MEASURE, 16'sd100, 1'b0);
        send_item(CMD_APPLY, 16'sd100, 1'b0);
        send_item(CMD_APPLY, -16'sd100, 1'b1);
        send_item(CMD_MEASURE, 16'sd50, 1'b0);
        send_item(CMD_APPLY, 16'sd50, 1'b1);
        wait_idle();
        apply_config(1'b1, '1, '1);
        send_item(CMD_MEASURE, 16'sd1, 1'b0);
        send_item(CMD_APPLY, 16'sh7FFF, 1'b0);
        send_item(CMD_APPLY, -16'sd2, 1'b0);
        send_item(CMD_APPLY, 16'sd1, 1'b1);
    endtask

    task automatic test_random_blocks();
        int                          n, scale, sent;
        logic                        rp;
        logic [TARGET_W-1:0]         tgt;
        logic [AMP_W-1:0]            amp;
        logic signed [SAMPLE_W-1:0]  s;
        logic signed [SAMPLE_W-1:0]  blk [$];
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            rp  = 1'($urandom_range(0, 1));
            tgt = TARGET_W'($urandom_range(0, 32767));
            amp = AMP_W'($urandom_range(0, 63));
            case (ph)
                0: begin rp = 1'b1; tgt = TARGET_RST; amp = MAX_AMP_RST; end
                1: begin rp = 1'b0; tgt = '1; amp = '1; end
                2: begin rp = 1'b1; tgt = TARGET_W'(1); amp = AMP_W'(1); end
                3: begin rp = 1'b0; tgt = '0; amp = '1; end
                4: begin rp = 1'b1; tgt = '1; amp = '0; end
                default: ;
            endcase
            apply_config(rp, tgt, amp);
            idle_on = (ph != PHASES - 1);
            sent = 0;
            while (sent < PHASE_BEATS) begin
                if ($urandom_range(0, 9) < 8) begin
                    // measure a block, then apply the same samples
                    n     = $urandom_range(1, 12);
                    scale = $urandom_range(0, SAMPLE_W - 1);
                    blk.delete();
                    for (int k = 0; k < n; k++) begin
                        s = SAMPLE_W'($urandom);
                        blk.insert(blk.size(), s >>> scale);
                    end
                    for (int k = 0; k < n; k++)
                        send_item(CMD_MEASURE, blk[k], (k == n - 1) && ($urandom_range(0, 3) == 0));
                    for (int k = 0; k < n; k++)
                        send_item(CMD_APPLY, blk[k], k == n - 1);
                    sent += 2 * n;
                end else begin
                    s = SAMPLE_W'($urandom);
                    send_item(1'($urandom_range(0, 1)), s >>> $urandom_range(0, SAMPLE_W - 1),
                              1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
    endtask

    // Receiver stall bursts
    always @(posedge i_clk) begin
        if (out_hold_cnt > 0) begin
            out_hold_cnt = out_hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_hold_cnt = $urandom_range(1, 11) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (scaled_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat: sample_out %0d last_out %0b",
                             o_out_data.sample_out, o_out_data.last_out);
            end else begin
                want = scaled_samples.pop_front();
                if (o_out_data.sample_out !== want.sample_out ||
                    o_out_data.last_out !== want.last_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("output mismatch: expected %0d/%0b, got %0d/%0b",
                                 want.sample_out, want.last_out,
                                 o_out_data.sample_out, o_out_data.last_out);
                end
            end
        end
    end

    // Stop a hung run: count cycles without any accepted beat or write.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** peak_audio_normalizer: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unity_and_clipping();
        test_peak_tracking();
        test_full_scale_negative();
        test_register_extremes();
        test_random_blocks();
        wait_idle();
        if (mismatches == 0 && scaled_samples.size() == 0) begin
            $display("** peak_audio_normalizer: PASSED **");
        end else begin
            $display("** peak_audio_normalizer: FAILED **");
        end
        $finish;
    end

endmodule
